// ===== sv/go_to_goal_heading_controller_assert.svh =====
// ---------------------------------------------------------------------------
// Assertion macros for the go-to-goal heading controller.
// Each macro expects a clock named clk and a synchronous reset named rst in
// the scope where it is used.
// ---------------------------------------------------------------------------
`ifndef GO_TO_GOAL_HEADING_CONTROLLER_ASSERT_SVH
`define GO_TO_GOAL_HEADING_CONTROLLER_ASSERT_SVH

// Same-cycle implication, disabled during reset.
`define GTG_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, disabled during reset.
`define GTG_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== sv/gtg_pkg.sv =====
// ---------------------------------------------------------------------------
// gtg_pkg
// Types, constants and the arctangent table shared by the heading controller.
// ---------------------------------------------------------------------------
`default_nettype none

package gtg_pkg;

  // Number of CORDIC micro-rotations by default, and the table size.
  localparam int CORDIC_STAGES_DEF = 16;
  localparam int CORDIC_STAGES_MAX = 24;

  // Rotating vector width: 17-bit deltas grow by the CORDIC gain.
  localparam int COORD_W = 20;

  // Square root: radicand, working root and final distance widths.
  localparam int SQRT_STEPS = 17;
  localparam int RAD_W      = 33;
  localparam int ROOT_W     = 34;
  localparam int DIST_W     = 17;

  // Configuration register reset values.
  localparam logic [14:0] TOL_RESET        = 15'd1043;
  localparam logic [15:0] TURN_GAIN_RESET  = 16'd205;
  localparam logic [15:0] DRIVE_GAIN_RESET = 16'd2048;

  // Configuration register indexes.
  typedef enum logic [2:0] {
    CFG_GOAL_X     = 3'd0,
    CFG_GOAL_Y     = 3'd1,
    CFG_TOLERANCE  = 3'd2,
    CFG_TURN_GAIN  = 3'd3,
    CFG_DRIVE_GAIN = 3'd4
  } cfg_reg_t;

  // Gains and tolerance as seen by the output stages.
  typedef struct packed {
    logic [14:0] tolerance;
    logic [15:0] turn_gain;
    logic [15:0] drive_gain;
  } gtg_cfg_t;

  // One pipeline slot: bearing and distance computed side by side.
  typedef struct packed {
    logic [15:0]               heading;
    logic                      zero;
    logic signed [COORD_W-1:0] x;
    logic signed [COORD_W-1:0] y;
    logic [31:0]               angle;
    logic [RAD_W-1:0]          rad;
    logic [ROOT_W-1:0]         root;
  } gtg_pipe_t;

  // atan(2^-i) as a 32-bit binary angle.
  function automatic logic [31:0] atan_angle(input logic [4:0] step);
    logic [31:0] a;
    case (step)
      5'd0:    a = 32'h20000000;
      5'd1:    a = 32'h12E4051E;
      5'd2:    a = 32'h09FB385B;
      5'd3:    a = 32'h051111D4;
      5'd4:    a = 32'h028B0D43;
      5'd5:    a = 32'h0145D7E1;
      5'd6:    a = 32'h00A2F61E;
      5'd7:    a = 32'h00517C55;
      5'd8:    a = 32'h0028BE53;
      5'd9:    a = 32'h00145F2F;
      5'd10:   a = 32'h000A2F98;
      5'd11:   a = 32'h000517CC;
      5'd12:   a = 32'h00028BE6;
      5'd13:   a = 32'h000145F3;
      5'd14:   a = 32'h0000A2FA;
      5'd15:   a = 32'h0000517D;
      5'd16:   a = 32'h000028BE;
      5'd17:   a = 32'h0000145F;
      5'd18:   a = 32'h00000A30;
      5'd19:   a = 32'h00000518;
      5'd20:   a = 32'h0000028C;
      5'd21:   a = 32'h00000146;
      5'd22:   a = 32'h000000A3;
      5'd23:   a = 32'h00000051;
      default: a = 32'h00000000;
    endcase
    return a;
  endfunction

endpackage

`default_nettype wire

// ===== sv/gtg_front.sv =====
// ---------------------------------------------------------------------------
// gtg_front
// Three front stages: goal deltas, their squares, then the radicand sum and
// the half-plane pre-rotation that starts the CORDIC.
// ---------------------------------------------------------------------------
`default_nettype none

module gtg_front
  import gtg_pkg::*;
(
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire logic               in_valid,
  input  wire logic signed [15:0] pos_x,
  input  wire logic signed [15:0] pos_y,
  input  wire logic signed [15:0] heading,
  input  wire logic signed [15:0] goal_x,
  input  wire logic signed [15:0] goal_y,
  output logic                    out_valid,
  output gtg_pipe_t               out_data
);

  logic               valid_a;
  logic signed [16:0] dx_a;
  logic signed [16:0] dy_a;
  logic [15:0]        head_a;

  logic               valid_b;
  logic signed [16:0] dx_b;
  logic signed [16:0] dy_b;
  logic [15:0]        head_b;
  logic [31:0]        sqx_b;
  logic [31:0]        sqy_b;

  logic signed [33:0] sqx_full;
  logic signed [33:0] sqy_full;
  logic signed [COORD_W-1:0] dx_ext;
  logic signed [COORD_W-1:0] dy_ext;
  gtg_pipe_t          data_next;

  // Valid bits travel with the data.
  always_ff @(posedge clk) begin
    if (rst) begin
      valid_a   <= 1'b0;
      valid_b   <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      valid_a   <= in_valid;
      valid_b   <= valid_a;
      out_valid <= valid_b;
    end
  end

  // Stage A: vector from robot to goal.
  always_ff @(posedge clk) begin
    dx_a   <= 17'({goal_x[15], goal_x}) - 17'({pos_x[15], pos_x});
    dy_a   <= 17'({goal_y[15], goal_y}) - 17'({pos_y[15], pos_y});
    head_a <= heading;
  end

  // Stage B: squares for the distance.
  assign sqx_full = dx_a * dx_a;
  assign sqy_full = dy_a * dy_a;

  always_ff @(posedge clk) begin
    dx_b   <= dx_a;
    dy_b   <= dy_a;
    head_b <= head_a;
    sqx_b  <= sqx_full[31:0];
    sqy_b  <= sqy_full[31:0];
  end

  // Stage C: radicand and pre-rotation into the right half plane.
  assign dx_ext = {{(COORD_W-17){dx_b[16]}}, dx_b};
  assign dy_ext = {{(COORD_W-17){dy_b[16]}}, dy_b};

  always_comb begin
    data_next.heading = head_b;
    data_next.zero    = (dx_b == 17'sd0) && (dy_b == 17'sd0);
    data_next.rad     = RAD_W'({1'b0, sqx_b}) + RAD_W'({1'b0, sqy_b});
    data_next.root    = '0;
    if (dx_b[16]) begin
      data_next.x     = -dx_ext;
      data_next.y     = -dy_ext;
      data_next.angle = 32'h80000000;
    end else begin
      data_next.x     = dx_ext;
      data_next.y     = dy_ext;
      data_next.angle = 32'h00000000;
    end
  end

  always_ff @(posedge clk) begin
    out_data <= data_next;
  end

endmodule

`default_nettype wire

// ===== sv/gtg_step.sv =====
// ---------------------------------------------------------------------------
// gtg_step
// One pipeline stage: a CORDIC vectoring micro-rotation and one digit of the
// square root, each only while its step index is in range.
// ---------------------------------------------------------------------------
`default_nettype none

module gtg_step
  import gtg_pkg::*;
#(
  parameter int STEP          = 0,
  parameter int CORDIC_STAGES = CORDIC_STAGES_DEF
)
(
  input  wire logic      clk,
  input  wire logic      rst,
  input  wire logic      in_valid,
  input  wire gtg_pipe_t in_data,
  output logic           out_valid,
  output gtg_pipe_t      out_data
);

  localparam int BIT_POS = (STEP < SQRT_STEPS) ? 2 * (SQRT_STEPS - 1 - STEP) : 0;
  localparam logic [ROOT_W-1:0] TRIAL_BIT = ROOT_W'(1) << BIT_POS;
  localparam logic [31:0] ATAN_STEP = atan_angle(5'(STEP));

  logic signed [COORD_W-1:0] xs;
  logic signed [COORD_W-1:0] ys;
  logic signed [COORD_W-1:0] sx;
  logic signed [COORD_W-1:0] sy;
  logic [ROOT_W:0]           trial_sum;
  gtg_pipe_t                 data_next;

  assign xs = in_data.x;
  assign ys = in_data.y;
  assign sx = xs >>> STEP;
  assign sy = ys >>> STEP;
  assign trial_sum = {1'b0, in_data.root} + {1'b0, TRIAL_BIT};

  // Rotate towards the x axis and take one root digit.
  always_comb begin
    data_next = in_data;
    if (STEP < CORDIC_STAGES) begin
      if (!ys[COORD_W-1]) begin
        data_next.x     = xs + sy;
        data_next.y     = ys - sx;
        data_next.angle = in_data.angle + ATAN_STEP;
      end else begin
        data_next.x     = xs - sy;
        data_next.y     = ys + sx;
        data_next.angle = in_data.angle - ATAN_STEP;
      end
    end
    if (STEP < SQRT_STEPS) begin
      if ((ROOT_W+1)'(in_data.rad) >= trial_sum) begin
        data_next.rad  = in_data.rad - RAD_W'(trial_sum);
        data_next.root = (in_data.root >> 1) + TRIAL_BIT;
      end else begin
        data_next.root = in_data.root >> 1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else begin
      out_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    out_data <= data_next;
  end

endmodule

`default_nettype wire

// ===== sv/gtg_back.sv =====
// ---------------------------------------------------------------------------
// gtg_back
// Four output stages: rounding of bearing and distance, heading error and
// alignment test, gain multiplies, then negation, rounding, saturation and
// the result register.
// ---------------------------------------------------------------------------
`default_nettype none

module gtg_back
  import gtg_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        in_valid,
  input  wire gtg_pipe_t   in_data,
  input  wire gtg_cfg_t    cfg,
  output logic             done,
  output logic signed [15:0] turn_rate,
  output logic [15:0]      forward_speed,
  output logic             aligned
);

  logic              valid_1;
  logic              valid_2;
  logic              valid_3;

  logic [DIST_W-1:0] dist_1;
  logic [15:0]       bear_1;
  logic [15:0]       head_1;

  logic [DIST_W-1:0] dist_2;
  logic signed [15:0] err_2;
  logic              aligned_2;

  logic signed [32:0] turn_prod_3;
  logic [32:0]        fwd_prod_3;
  logic               aligned_3;

  logic signed [15:0] err_next;
  logic signed [16:0] err_ext;
  logic [16:0]        err_mag;
  logic signed [33:0] turn_sum;
  logic signed [33:0] turn_q;
  logic [33:0]        fwd_sum;
  logic [21:0]        fwd_q;
  logic signed [15:0] turn_sat;
  logic [15:0]        fwd_sat;

  always_ff @(posedge clk) begin
    if (rst) begin
      valid_1 <= 1'b0;
      valid_2 <= 1'b0;
      valid_3 <= 1'b0;
      done    <= 1'b0;
    end else begin
      valid_1 <= in_valid;
      valid_2 <= valid_1;
      valid_3 <= valid_2;
      done    <= valid_3;
    end
  end

  // Stage 1: round the root to nearest and the angle to 16 bits.
  always_ff @(posedge clk) begin
    dist_1 <= in_data.root[DIST_W-1:0] +
              DIST_W'({1'b0, in_data.rad} > in_data.root);
    bear_1 <= in_data.zero ? 16'h0000 :
              in_data.angle[31:16] + 16'(in_data.angle[15]);
    head_1 <= in_data.heading;
  end

  // Stage 2: wrapped heading error and tolerance test.
  assign err_next = $signed(head_1 - bear_1);
  assign err_ext  = {err_next[15], err_next};
  assign err_mag  = err_ext[16] ? 17'(-err_ext) : 17'(err_ext);

  always_ff @(posedge clk) begin
    dist_2    <= dist_1;
    err_2     <= err_next;
    aligned_2 <= err_mag <= {2'b00, cfg.tolerance};
  end

  // Stage 3: gain products.
  always_ff @(posedge clk) begin
    turn_prod_3 <= $signed({1'b0, cfg.turn_gain}) * err_2;
    fwd_prod_3  <= cfg.drive_gain * dist_2;
    aligned_3   <= aligned_2;
  end

  // Stage 4: negate, round to nearest, saturate.
  assign turn_sum = 34'sd2048 - {turn_prod_3[32], turn_prod_3};
  assign turn_q   = turn_sum >>> 12;
  assign fwd_sum  = {1'b0, fwd_prod_3} + 34'd2048;
  assign fwd_q    = fwd_sum[33:12];

  always_comb begin
    if (turn_q > 34'sd32767) begin
      turn_sat = 16'sh7FFF;
    end else if (turn_q < -34'sd32768) begin
      turn_sat = 16'sh8000;
    end else begin
      turn_sat = turn_q[15:0];
    end
    fwd_sat = (|fwd_q[21:16]) ? 16'hFFFF : fwd_q[15:0];
  end

  always_ff @(posedge clk) begin
    turn_rate     <= aligned_3 ? 16'sd0 : turn_sat;
    forward_speed <= aligned_3 ? fwd_sat : 16'd0;
    aligned       <= aligned_3;
  end

endmodule

`default_nettype wire

// ===== sv/go_to_goal_heading_controller.sv =====
// ---------------------------------------------------------------------------
// go_to_goal_heading_controller
// Proportional go-to-goal controller: bearing by a pipelined vectoring CORDIC,
// distance by a pipelined digit-by-digit square root, then turn-or-drive.
// ---------------------------------------------------------------------------
// Usage.
// A pose (pos_x, pos_y, heading) is taken at a rising edge with start high
// and busy low. busy is high only during reset and in the cycle after it,
// so a pose can be given in every cycle. Each pose gives one command: done
// is high for one cycle with turn_rate, forward_speed and aligned valid in
// that cycle only. Throughput is one pose per clock while busy is low. The
// pipeline runs the per-stage CORDIC rotations and the 17 root digits side
// by side, between three front and four back stages; the first front
// register is loaded at the accepting edge itself.
// The command sink has no back-pressure; the pipeline never halts.
// Configuration goes through cfg_valid/cfg_ready/cfg_index/cfg_data, always
// ready, one register a beat; write it only while no pose is in flight.
// Reset empties the pipeline and restores every configuration register to its default.
// ---------------------------------------------------------------------------
`default_nettype none

`include "go_to_goal_heading_controller_assert.svh"

module go_to_goal_heading_controller
  import gtg_pkg::*;
#(
  parameter int CORDIC_STAGES = CORDIC_STAGES_DEF
)
(
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire logic               start,
  output logic                    busy,
  input  wire logic signed [15:0] pos_x,
  input  wire logic signed [15:0] pos_y,
  input  wire logic signed [15:0] heading,
  output logic                    done,
  output logic signed [15:0]      turn_rate,
  output logic [15:0]             forward_speed,
  output logic                    aligned,
  input  wire logic               cfg_valid,
  output logic                    cfg_ready,
  input  wire logic [2:0]         cfg_index,
  input  wire logic [15:0]        cfg_data
);

  localparam int DEPTH = (CORDIC_STAGES > SQRT_STEPS) ? CORDIC_STAGES : SQRT_STEPS;

  logic signed [15:0] goal_x;
  logic signed [15:0] goal_y;
  logic [14:0]        heading_tolerance;
  logic [15:0]        turn_gain;
  logic [15:0]        drive_gain;
  gtg_cfg_t           cfg;
  logic               goal_x_wr;

  logic               pipe_valid [DEPTH+1];
  gtg_pipe_t          pipe_data  [DEPTH+1];

  // Held off during reset and in the cycle after it.
  always_ff @(posedge clk) begin
    busy <= rst;
  end

  assign cfg_ready = 1'b1;

  // Configuration registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      goal_x            <= 16'sd0;
      goal_y            <= 16'sd0;
      heading_tolerance <= TOL_RESET;
      turn_gain         <= TURN_GAIN_RESET;
      drive_gain        <= DRIVE_GAIN_RESET;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_reg_t'(cfg_index))
        CFG_GOAL_X:     goal_x            <= cfg_data;
        CFG_GOAL_Y:     goal_y            <= cfg_data;
        CFG_TOLERANCE:  heading_tolerance <= cfg_data[14:0];
        CFG_TURN_GAIN:  turn_gain         <= cfg_data;
        CFG_DRIVE_GAIN: drive_gain        <= cfg_data;
        default: ;
      endcase
    end
  end

  assign cfg.tolerance  = heading_tolerance;
  assign cfg.turn_gain  = turn_gain;
  assign cfg.drive_gain = drive_gain;

  // Front stages: deltas, squares, pre-rotation.
  gtg_front u_front (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (start && !busy),
    .pos_x     (pos_x),
    .pos_y     (pos_y),
    .heading   (heading),
    .goal_x    (goal_x),
    .goal_y    (goal_y),
    .out_valid (pipe_valid[0]),
    .out_data  (pipe_data[0])
  );

  // Rotation and root stages.
  for (genvar i = 0; i < DEPTH; i++) begin : g_step
    gtg_step #(
      .STEP          (i),
      .CORDIC_STAGES (CORDIC_STAGES)
    ) u_step (
      .clk       (clk),
      .rst       (rst),
      .in_valid  (pipe_valid[i]),
      .in_data   (pipe_data[i]),
      .out_valid (pipe_valid[i+1]),
      .out_data  (pipe_data[i+1])
    );
  end

  // Output stages.
  gtg_back u_back (
    .clk           (clk),
    .rst           (rst),
    .in_valid      (pipe_valid[DEPTH]),
    .in_data       (pipe_data[DEPTH]),
    .cfg           (cfg),
    .done          (done),
    .turn_rate     (turn_rate),
    .forward_speed (forward_speed),
    .aligned       (aligned)
  );

  // A goal x write beat.
  assign goal_x_wr = cfg_valid && cfg_ready && (cfg_index == CFG_GOAL_X);

  // While aligned the robot must not turn, and while turning it must not drive.
  `GTG_ASSERT_IMP(a_no_turn_aligned, done && aligned, turn_rate == 16'sd0, "turn while aligned")
  `GTG_ASSERT_IMP(a_no_drive_turning, done && !aligned, forward_speed == 16'd0, "drive while turning")
  // A goal write lands in the register on the next cycle.
  `GTG_ASSERT_NXT(a_goal_x_write, goal_x_wr, goal_x == $past(cfg_data), "goal_x write lost")

endmodule

`default_nettype wire
